>>> hw/rtl/kts_pkg.sv
// ----------------------------------------------------------------------------
// Keyframe track sampler package
// Shared types, codes and helpers for the key store, controller and datapath.
// ----------------------------------------------------------------------------
package kts_pkg;

   // Key word layout: time, x, y, z (32 bits each) and w (16 bits).
   localparam int WORD_W = 144;
   localparam int F_W    = 48;
   localparam int ACC_W  = 81;

   // Result status codes.
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_EMPTY   = 2'd1;
   localparam logic [1:0] ST_EQUAL   = 2'd2;
   localparam logic [1:0] ST_WRITTEN = 2'd3;

   // Result source select codes.
   localparam logic [2:0] OUT_ZERO  = 3'd0;
   localparam logic [2:0] OUT_CUR   = 3'd1;
   localparam logic [2:0] OUT_PREV  = 3'd2;
   localparam logic [2:0] OUT_BLEND = 3'd3;

   // Iteration counts of the serial divider and square root units.
   localparam logic [5:0] FRAC_STEPS = 6'd48;
   localparam logic [5:0] SQRT_STEPS = 6'd32;
   localparam logic [5:0] NORM_STEPS = 6'd16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;
      logic       write;
      logic       scan_clr;
      logic       rd;
      logic       shift;
      logic       s_inc;
      logic       frac_load;
      logic       div_step;
      logic       f_load;
      logic       mul_lo;
      logic       mul_hi;
      logic       mul_sq;
      logic       blend_store;
      logic       sum_add;
      logic       sqrt_load;
      logic       sqrt_step;
      logic       ndiv_load;
      logic       q_store;
      logic [1:0] comp;
      logic       emit;
      logic [2:0] out_sel;
      logic [1:0] status;
   } kts_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_write;
      logic is_rot;
      logic empty;
      logic scan_go;
      logic s_zero;
      logic den_zero;
      logic sum_zero;
   } kts_sts_type;

   // Time stamp of a key word.
   function automatic logic signed [31:0] word_time(input logic [WORD_W-1:0] w);
      return $signed(w[143:112]);
   endfunction

   // One value component of a key word, w sign-extended.
   function automatic logic signed [31:0] word_comp(input logic [WORD_W-1:0] w,
                                                    input logic [1:0] c);
      logic signed [31:0] v;
      case (c)
         2'd0:    v = $signed(w[111:80]);
         2'd1:    v = $signed(w[79:48]);
         2'd2:    v = $signed(w[47:16]);
         default: v = $signed({{16{w[15]}}, w[15:0]});
      endcase
      return v;
   endfunction

   // Saturate a 32-bit signed value to 16 bits.
   function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
      logic signed [15:0] r;
      if (v > 32'sd32767) begin
         r = 16'sd32767;
      end else if (v < -32'sd32768) begin
         r = -16'sd32768;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

>>> hw/rtl/kts_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module kts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/kts_ctrl.sv
// ----------------------------------------------------------------------------
// Keyframe track sampler controller
// Sequences decode, key scan, fraction divide, blend, normalize and result.
// ----------------------------------------------------------------------------
module kts_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output kts_pkg::kts_cmd_type cmd,
   input  kts_pkg::kts_sts_type sts
);
   import kts_pkg::*;

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_DECODE    = 5'd1;
   localparam logic [4:0] S_SCAN_RD   = 5'd2;
   localparam logic [4:0] S_SCAN_CMP  = 5'd3;
   localparam logic [4:0] S_FIRST     = 5'd4;
   localparam logic [4:0] S_FRAC      = 5'd5;
   localparam logic [4:0] S_DIV_F     = 5'd6;
   localparam logic [4:0] S_F_DONE    = 5'd7;
   localparam logic [4:0] S_MUL_LO    = 5'd8;
   localparam logic [4:0] S_MUL_HI    = 5'd9;
   localparam logic [4:0] S_BLEND_FIN = 5'd10;
   localparam logic [4:0] S_SQ_LO     = 5'd11;
   localparam logic [4:0] S_SQ_HI     = 5'd12;
   localparam logic [4:0] S_SQ_FIN    = 5'd13;
   localparam logic [4:0] S_SQRT_INIT = 5'd14;
   localparam logic [4:0] S_SQRT_STEP = 5'd15;
   localparam logic [4:0] S_NDIV_INIT = 5'd16;
   localparam logic [4:0] S_NDIV_STEP = 5'd17;
   localparam logic [4:0] S_NDIV_FIN  = 5'd18;
   localparam logic [4:0] S_EMIT_B    = 5'd19;

   logic [4:0] state_ff, state_in;
   logic [5:0] iter_ff, iter_in;
   logic [1:0] comp_ff, comp_in;

   assign busy = (state_ff != S_IDLE);

   // State, iteration and component registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
         comp_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
         comp_ff  <= comp_in;
      end
   end

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      comp_in  = comp_ff;
      cmd      = '0;
      cmd.comp = comp_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.is_write) begin
               cmd.write   = 1'b1;
               cmd.emit    = 1'b1;
               cmd.out_sel = OUT_ZERO;
               cmd.status  = ST_WRITTEN;
               state_in    = S_IDLE;
            end else if (sts.empty) begin
               cmd.emit    = 1'b1;
               cmd.out_sel = OUT_ZERO;
               cmd.status  = ST_EMPTY;
               state_in    = S_IDLE;
            end else begin
               cmd.scan_clr = 1'b1;
               state_in     = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            cmd.shift = 1'b1;
            if (sts.scan_go) begin
               cmd.s_inc = 1'b1;
               state_in  = S_SCAN_RD;
            end else if (sts.s_zero) begin
               state_in = S_FIRST;
            end else begin
               state_in = S_FRAC;
            end
         end
         S_FIRST: begin
            cmd.emit    = 1'b1;
            cmd.out_sel = OUT_CUR;
            cmd.status  = ST_OK;
            state_in    = S_IDLE;
         end
         S_FRAC: begin
            if (sts.den_zero) begin
               cmd.emit    = 1'b1;
               cmd.out_sel = OUT_PREV;
               cmd.status  = ST_EQUAL;
               state_in    = S_IDLE;
            end else begin
               cmd.frac_load = 1'b1;
               iter_in       = FRAC_STEPS - 6'd1;
               state_in      = S_DIV_F;
            end
         end
         S_DIV_F: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff - 6'd1;
            if (iter_ff == '0) begin
               state_in = S_F_DONE;
            end
         end
         S_F_DONE: begin
            cmd.f_load = 1'b1;
            comp_in    = '0;
            state_in   = S_MUL_LO;
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_BLEND_FIN;
         end
         S_BLEND_FIN: begin
            cmd.blend_store = 1'b1;
            if (sts.is_rot) begin
               state_in = S_SQ_LO;
            end else if (comp_ff == 2'd2) begin
               state_in = S_EMIT_B;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_MUL_LO;
            end
         end
         S_SQ_LO: begin
            cmd.mul_lo = 1'b1;
            cmd.mul_sq = 1'b1;
            state_in   = S_SQ_HI;
         end
         S_SQ_HI: begin
            cmd.mul_hi = 1'b1;
            cmd.mul_sq = 1'b1;
            state_in   = S_SQ_FIN;
         end
         S_SQ_FIN: begin
            cmd.sum_add = 1'b1;
            if (comp_ff == 2'd3) begin
               state_in = S_SQRT_INIT;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_MUL_LO;
            end
         end
         S_SQRT_INIT: begin
            if (sts.sum_zero) begin
               cmd.emit    = 1'b1;
               cmd.out_sel = OUT_ZERO;
               cmd.status  = ST_OK;
               state_in    = S_IDLE;
            end else begin
               cmd.sqrt_load = 1'b1;
               iter_in       = SQRT_STEPS - 6'd1;
               state_in      = S_SQRT_STEP;
            end
         end
         S_SQRT_STEP: begin
            cmd.sqrt_step = 1'b1;
            iter_in       = iter_ff - 6'd1;
            if (iter_ff == '0) begin
               comp_in  = '0;
               state_in = S_NDIV_INIT;
            end
         end
         S_NDIV_INIT: begin
            cmd.ndiv_load = 1'b1;
            iter_in       = NORM_STEPS - 6'd1;
            state_in      = S_NDIV_STEP;
         end
         S_NDIV_STEP: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff - 6'd1;
            if (iter_ff == '0) begin
               state_in = S_NDIV_FIN;
            end
         end
         S_NDIV_FIN: begin
            cmd.q_store = 1'b1;
            if (comp_ff == 2'd3) begin
               state_in = S_EMIT_B;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_NDIV_INIT;
            end
         end
         S_EMIT_B: begin
            cmd.emit    = 1'b1;
            cmd.out_sel = OUT_BLEND;
            cmd.status  = ST_OK;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/kts_datapath.sv
// ----------------------------------------------------------------------------
// Keyframe track sampler datapath
// Key store, key counts, scan compare, shared multiplier, divider and
// square root, and the result registers.
// ----------------------------------------------------------------------------
module kts_datapath #(
   parameter int NUM_CHANNELS = 16,
   parameter int MAX_KEYS     = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  kts_pkg::kts_cmd_type cmd,
   output kts_pkg::kts_sts_type sts,
   input  logic                 req_opcode,
   input  logic                 req_track,
   input  logic [3:0]           req_channel,
   input  logic [5:0]           req_key_index,
   input  logic signed [31:0]   req_time_value,
   input  logic signed [31:0]   req_val_x,
   input  logic signed [31:0]   req_val_y,
   input  logic signed [31:0]   req_val_z,
   input  logic signed [15:0]   req_val_w,
   output logic                 rsp_valid,
   output logic signed [31:0]   rsp_out_x,
   output logic signed [31:0]   rsp_out_y,
   output logic signed [31:0]   rsp_out_z,
   output logic signed [15:0]   rsp_out_w,
   output logic [1:0]           rsp_status
);
   import kts_pkg::*;

   localparam int CHW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int KW    = $clog2(MAX_KEYS);
   localparam int CW    = $clog2(MAX_KEYS + 1);
   localparam int NSLOT = NUM_CHANNELS * MAX_KEYS;
   localparam int DEPTH = 2 * NSLOT;
   localparam int AW    = $clog2(DEPTH);

   // Request registers.
   logic               op_ff, trk_ff;
   logic [3:0]         ch_ff;
   logic [5:0]         ki_ff;
   logic signed [31:0] t_ff, vx_ff, vy_ff, vz_ff;
   logic signed [15:0] vw_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff  <= req_opcode;
         trk_ff <= req_track;
         ch_ff  <= req_channel;
         ki_ff  <= req_key_index;
         t_ff   <= req_time_value;
         vx_ff  <= req_val_x;
         vy_ff  <= req_val_y;
         vz_ff  <= req_val_z;
         vw_ff  <= req_val_w;
      end
   end

   // Addressing and range checks.
   logic          ch_valid, ki_valid, wr_ok;
   logic [CHW-1:0] ch_idx;
   logic [KW-1:0]  ki_idx;
   logic [AW-1:0]  base, wr_addr, rd_addr;
   logic [KW-1:0]  s_ff;

   assign ch_valid = (32'(ch_ff) < 32'(NUM_CHANNELS));
   assign ki_valid = (32'(ki_ff) < 32'(MAX_KEYS));
   assign wr_ok    = cmd.write && ch_valid && ki_valid;
   assign ch_idx   = CHW'(ch_ff);
   assign ki_idx   = KW'(ki_ff);
   assign base     = AW'(trk_ff) * AW'(NSLOT) + AW'(ch_idx) * AW'(MAX_KEYS);
   assign wr_addr  = base + AW'(ki_idx);
   assign rd_addr  = base + AW'(s_ff);

   // Key counts per track and channel.
   logic [CW-1:0] cnt_ff [2][NUM_CHANNELS];
   logic [CW-1:0] cnt_cur;

   assign cnt_cur = cnt_ff[trk_ff][ch_idx];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < NUM_CHANNELS; j++) begin
               cnt_ff[i][j] <= '0;
            end
         end
      end else if (wr_ok) begin
         cnt_ff[trk_ff][ch_idx] <= CW'(ki_idx) + CW'(1);
      end
   end

   // Key store write data; rotation parts are saturated to 16 bits.
   logic [WORD_W-1:0] wr_data, rd_data;
   logic signed [15:0] sx, sy, sz;

   assign sx = sat16(vx_ff);
   assign sy = sat16(vy_ff);
   assign sz = sat16(vz_ff);

   always_comb begin
      if (trk_ff) begin
         wr_data = {t_ff, {{16{sx[15]}}, sx}, {{16{sy[15]}}, sy},
                    {{16{sz[15]}}, sz}, vw_ff};
      end else begin
         wr_data = {t_ff, vx_ff, vy_ff, vz_ff, 16'd0};
      end
   end

   kts_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_ok),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Scan over the keys: current and previous words.
   logic [WORD_W-1:0] cur_ff, prev_ff;

   always_ff @(posedge clock) begin
      if (cmd.scan_clr) begin
         s_ff <= '0;
      end else if (cmd.s_inc) begin
         s_ff <= s_ff + KW'(1);
      end
      if (cmd.shift) begin
         prev_ff <= cur_ff;
         cur_ff  <= rd_data;
      end
   end

   // Fraction operands.
   logic signed [31:0] t0, t1;
   logic signed [32:0] den, num;
   logic [32:0]        den_mag, num_mag;

   assign t0      = word_time(prev_ff);
   assign t1      = word_time(cur_ff);
   assign den     = {t1[31], t1} - {t0[31], t0};
   assign num     = {t_ff[31], t_ff} - {t0[31], t0};
   assign den_mag = den[32] ? 33'(-den) : 33'(den);
   assign num_mag = num[32] ? 33'(-num) : 33'(num);

   // Shared restoring divider, one quotient bit per cycle.
   logic [33:0]    div_rem_ff;
   logic [63:0]    div_sh_ff;
   logic [32:0]    div_dvs_ff;
   logic [F_W-1:0] div_q_ff;
   logic [33:0]    div_rem_sh, div_diff;
   logic           div_ge;

   assign div_rem_sh = {div_rem_ff[32:0], div_sh_ff[63]};
   assign div_diff   = div_rem_sh - {1'b0, div_dvs_ff};
   assign div_ge     = (div_rem_sh >= {1'b0, div_dvs_ff});

   // Square root unit, two radicand bits per cycle.
   logic [63:0] sum_ff;
   logic        small_ff;
   logic [63:0] sq_sh_ff;
   logic [34:0] sq_rem_ff;
   logic [31:0] sq_root_ff;
   logic [34:0] sq_rem_sh, sq_trial;
   logic        sq_ge;

   assign sq_rem_sh = {sq_rem_ff[32:0], sq_sh_ff[63:62]};
   assign sq_trial  = {1'b0, sq_root_ff, 2'b01};
   assign sq_ge     = (sq_rem_sh >= sq_trial);

   // Blend operands and shared multiplier.
   logic signed [31:0] bl_ff [4];
   logic               f_neg_ff;
   logic [F_W-1:0]     f_mag_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic signed [31:0] va, vb, bc;
   logic signed [32:0] d;
   logic [32:0]        d_mag, mul_a;
   logic [30:0]        bc_mag;
   logic [F_W-1:0]     mul_b;
   logic [23:0]        mul_b_half;
   logic [56:0]        part;

   assign va         = word_comp(prev_ff, cmd.comp);
   assign vb         = word_comp(cur_ff, cmd.comp);
   assign d          = {vb[31], vb} - {va[31], va};
   assign d_mag      = d[32] ? 33'(-d) : 33'(d);
   assign bc         = bl_ff[cmd.comp];
   assign bc_mag     = bc[31] ? 31'(-bc) : 31'(bc);
   assign mul_a      = cmd.mul_sq ? {2'b00, bc_mag} : d_mag;
   assign mul_b      = cmd.mul_sq ? {17'd0, bc_mag} : f_mag_ff;
   assign mul_b_half = cmd.mul_hi ? mul_b[47:24] : mul_b[23:0];
   assign part       = 57'(mul_a * mul_b_half);

   // Blend result: a + (d*f)/65536 truncated, then saturated.
   logic               bneg, big;
   logic [64:0]        term_mag;
   logic signed [34:0] term, r35;
   logic signed [31:0] blend_r;

   assign bneg     = d[32] ^ f_neg_ff;
   assign term_mag = acc_ff[80:16];
   assign big      = |term_mag[64:33];
   assign term     = $signed({2'b00, term_mag[32:0]});
   assign r35      = $signed({{3{va[31]}}, va}) + (bneg ? -term : term);

   always_comb begin
      if (big) begin
         blend_r = bneg ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else if (r35 > 35'sd2147483647) begin
         blend_r = 32'sh7fff_ffff;
      end else if (r35 < -35'sd2147483648) begin
         blend_r = 32'sh8000_0000;
      end else begin
         blend_r = r35[31:0];
      end
      // Rotation parts stay within the symmetric range.
      if (trk_ff && blend_r == 32'sh8000_0000) begin
         blend_r = 32'sh8000_0001;
      end
   end

   // Arithmetic registers.
   always_ff @(posedge clock) begin
      if (cmd.frac_load) begin
         div_rem_ff <= 34'(num_mag >> 32);
         div_sh_ff  <= {num_mag[31:0], 32'd0};
         div_dvs_ff <= den_mag;
         div_q_ff   <= '0;
         f_neg_ff   <= num[32] ^ den[32];
      end else if (cmd.ndiv_load) begin
         if (small_ff) begin
            div_rem_ff <= 34'({bc_mag, 12'd0});
            div_sh_ff  <= '0;
         end else begin
            div_rem_ff <= 34'(bc_mag >> 2);
            div_sh_ff  <= {bc_mag[1:0], 62'd0};
         end
         div_dvs_ff <= {1'b0, sq_root_ff};
         div_q_ff   <= '0;
      end else if (cmd.div_step) begin
         div_rem_ff <= div_ge ? div_diff : div_rem_sh;
         div_sh_ff  <= {div_sh_ff[62:0], 1'b0};
         div_q_ff   <= {div_q_ff[F_W-2:0], div_ge};
      end

      if (cmd.f_load) begin
         f_mag_ff <= div_q_ff;
      end

      if (cmd.mul_lo) begin
         acc_ff <= ACC_W'(part);
      end else if (cmd.mul_hi) begin
         acc_ff <= acc_ff + {part, 24'd0};
      end

      if (cmd.blend_store) begin
         bl_ff[cmd.comp] <= blend_r;
      end else if (cmd.q_store) begin
         bl_ff[cmd.comp] <= bc[31] ? -32'(div_q_ff[15:0]) : 32'(div_q_ff[15:0]);
      end

      if (cmd.f_load) begin
         sum_ff <= '0;
      end else if (cmd.sum_add) begin
         sum_ff <= sum_ff + acc_ff[63:0];
      end

      if (cmd.sqrt_load) begin
         small_ff   <= (sum_ff[63:34] == '0);
         sq_sh_ff   <= (sum_ff[63:34] == '0) ? {sum_ff[35:0], 28'd0} : sum_ff;
         sq_rem_ff  <= '0;
         sq_root_ff <= '0;
      end else if (cmd.sqrt_step) begin
         sq_rem_ff  <= sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
         sq_root_ff <= {sq_root_ff[30:0], sq_ge};
         sq_sh_ff   <= {sq_sh_ff[61:0], 2'b00};
      end
   end

   // Status toward the controller.
   assign sts.is_write = !op_ff;
   assign sts.is_rot   = trk_ff;
   assign sts.empty    = !ch_valid || (cnt_cur == '0);
   assign sts.scan_go  = ((CW'(s_ff) + CW'(1)) < cnt_cur) && (t_ff > word_time(rd_data));
   assign sts.s_zero   = (s_ff == '0);
   assign sts.den_zero = (den == '0);
   assign sts.sum_zero = (sum_ff == '0);

   // Result registers.
   logic               rsp_valid_ff;
   logic signed [31:0] rsp_out_x_ff, rsp_out_y_ff, rsp_out_z_ff;
   logic signed [15:0] rsp_out_w_ff;
   logic [1:0]         rsp_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= cmd.status;
         case (cmd.out_sel)
            OUT_CUR: begin
               rsp_out_x_ff <= word_comp(cur_ff, 2'd0);
               rsp_out_y_ff <= word_comp(cur_ff, 2'd1);
               rsp_out_z_ff <= word_comp(cur_ff, 2'd2);
               rsp_out_w_ff <= trk_ff ? $signed(cur_ff[15:0]) : 16'sd0;
            end
            OUT_PREV: begin
               rsp_out_x_ff <= word_comp(prev_ff, 2'd0);
               rsp_out_y_ff <= word_comp(prev_ff, 2'd1);
               rsp_out_z_ff <= word_comp(prev_ff, 2'd2);
               rsp_out_w_ff <= trk_ff ? $signed(prev_ff[15:0]) : 16'sd0;
            end
            OUT_BLEND: begin
               rsp_out_x_ff <= bl_ff[0];
               rsp_out_y_ff <= bl_ff[1];
               rsp_out_z_ff <= bl_ff[2];
               rsp_out_w_ff <= trk_ff ? bl_ff[3][15:0] : 16'sd0;
            end
            default: begin
               rsp_out_x_ff <= '0;
               rsp_out_y_ff <= '0;
               rsp_out_z_ff <= '0;
               rsp_out_w_ff <= '0;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_out_x  = rsp_out_x_ff;
   assign rsp_out_y  = rsp_out_y_ff;
   assign rsp_out_z  = rsp_out_z_ff;
   assign rsp_out_w  = rsp_out_w_ff;
   assign rsp_status = rsp_status_ff;

endmodule

>>> hw/rtl/keyframe_track_sampler.sv
// ----------------------------------------------------------------------------
// Keyframe track sampler
// Stores translation and rotation key tracks per channel and samples them
// with linear blending; rotation results are normalized.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken when start is high and busy is low. A write item
//   (opcode 0) stores one key and sets the track length to key_index+1;
//   a sample item (opcode 1) returns the blended value at time_value.
//   Every item gives exactly one result, shown for one cycle with rsp_valid.
//   The receiver cannot stall; a result is on the ports while the next item
//   may already be taken, so one item completes before the next begins.
//   A write or an empty track is answered from the decode state. A
//   sample scans the keys, one read per key over the key store's single
//   read port, then runs a fraction divide, a blend per part, and for
//   rotation squares of the parts, a square root and a normalizing divide
//   per part. The scan compares 1 to 64 keys. A sample at or before the
//   first key, or between equal key times, ends after the scan with a
//   stored key as its result.
//   Reset clears all track lengths; stored keys are unknown until written.
// ----------------------------------------------------------------------------
module keyframe_track_sampler #(
   parameter int NUM_CHANNELS = 16,
   parameter int MAX_KEYS     = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_opcode,
   input  logic               req_track,
   input  logic [3:0]         req_channel,
   input  logic [5:0]         req_key_index,
   input  logic signed [31:0] req_time_value,
   input  logic signed [31:0] req_val_x,
   input  logic signed [31:0] req_val_y,
   input  logic signed [31:0] req_val_z,
   input  logic signed [15:0] req_val_w,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic signed [15:0] rsp_out_w,
   output logic [1:0]         rsp_status
);
   import kts_pkg::*;

   kts_cmd_type cmd;
   kts_sts_type sts;

   // Sequencer.
   kts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   // Key store and arithmetic.
   kts_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .MAX_KEYS     (MAX_KEYS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_opcode     (req_opcode),
      .req_track      (req_track),
      .req_channel    (req_channel),
      .req_key_index  (req_key_index),
      .req_time_value (req_time_value),
      .req_val_x      (req_val_x),
      .req_val_y      (req_val_y),
      .req_val_z      (req_val_z),
      .req_val_w      (req_val_w),
      .rsp_valid      (rsp_valid),
      .rsp_out_x      (rsp_out_x),
      .rsp_out_y      (rsp_out_y),
      .rsp_out_z      (rsp_out_z),
      .rsp_out_w      (rsp_out_w),
      .rsp_status     (rsp_status)
   );

endmodule
